FILE: hdl/su3p_pkg.sv
`default_nettype none
package su3p_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int NUM_ROWS       = 3;

  typedef enum logic [1:0] {
    ROW_ZERO = 2'd0,
    ROW_ONE  = 2'd1,
    ROW_TWO  = 2'd2
  } row_idx_t;

  typedef struct packed {
    logic     valid;
    logic     deg;
  } su3p_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/su3_projection_unit.sv
`default_nettype none
// su3 projection unit
// in_ channel: one item holds rows one and two of a complex 3x3 matrix
// out_ channel: three items per input, rows 0, 1, 2 in order; tlast marks
// row 2, tuser = {degenerate, row_index}
// the block is a fixed-depth pipeline: two normalizers (squares, norm, one
// quotient bit per stage) and two registered cross products; row 0 of an
// item is presented after it has passed through all of these and the serializer
// the single result channel serializes three rows per item and so sets the
// item rate; input is taken back to back until an item waits at the
// pipeline end while the serializer is busy
// whole pipeline advances unless an item waits at its end that the serializer
// cannot take, so a stall on out_tready then freezes the pipeline without loss
// reset (rst_n low, synchronous) clears all valid bits; no items in flight
module su3_projection_unit
  import su3p_pkg::*;
#(
  parameter int DATA_WIDTH = su3p_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = su3p_pkg::FRAC_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // a_re0, a_im0, a_re1, a_im1, a_re2, a_im2, b_re0 .. b_im2
  input  wire  [12*DATA_WIDTH-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // out_re0, out_im0, out_re1, out_im1, out_re2, out_im2
  output logic [6*DATA_WIDTH-1:0]   out_tdata,
  // row_index (2), degenerate (1)
  output logic [2:0]                out_tuser,
  output logic                      out_tlast
);
  localparam int VW1 = 2 * DATA_WIDTH + 4;
  localparam int CW  = 2 * DATA_WIDTH + 3;
  localparam int SW  = 6 * DATA_WIDTH;
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic en;
  logic signed [5:0][VW1-1:0] n1_in;
  logic                       n1_v, n1_z;
  logic signed [5:0][DATA_WIDTH-1:0] row0, row2, b_d, r0_d;
  logic [SW-1:0]              n1_side, n2_side;

  // serializer
  logic                       busy_r;
  logic [1:0]                 cnt_r;
  logic [SW-1:0]              s0_r, s1_r, s2_r;
  logic                       sdeg_r;

  logic last_take;
  assign last_take = out_tvalid && out_tready && (cnt_r == 2'(ROW_TWO));

  // pipeline stalls only when its output is valid and serializer is busy and not taking its last row
  logic pipe_out_v;
  assign en = !(pipe_out_v && busy_r && !last_take);
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      n1_in[k] = VW1'($signed(in_tdata[k*DATA_WIDTH +: DATA_WIDTH]));
    end
  end

  su3p_norm #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .VW(VW1)) u_n1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid && in_tready),
    .in_vec(n1_in), .in_side(in_tdata[12*DATA_WIDTH-1:SW]),
    .out_valid(n1_v), .out_zero(n1_z), .out_vec(row0), .out_side(n1_side)
  );

  always_comb begin
    for (int k = 0; k < 6; k++) b_d[k] = n1_side[k*DATA_WIDTH +: DATA_WIDTH];
  end

  logic signed [5:0][CW-1:0] c1;
  su3p_cross #(.AW(DATA_WIDTH), .BW(DATA_WIDTH), .RW(CW)) u_c1 (
    .clk(clk), .en(en), .p(row0), .q(b_d), .d(c1)
  );

  logic c1_v_r, c1_z_r;
  logic [SW-1:0] c1_row0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c1_v_r <= 1'b0;
    else if (en) c1_v_r <= n1_v;
    if (en) begin
      c1_z_r    <= n1_z;
      c1_row0_r <= row0;
    end
  end

  logic signed [5:0][VW1-1:0] n2_in;
  always_comb begin
    for (int k = 0; k < 6; k++) n2_in[k] = VW1'($signed(c1[k]));
  end

  logic n2_v, n2_z;
  su3p_norm #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .VW(VW1)) u_n2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c1_v_r),
    .in_vec(n2_in), .in_side(c1_row0_r),
    .out_valid(n2_v), .out_zero(n2_z), .out_vec(row2), .out_side(n2_side)
  );

  // degenerate flag of the first norm rides along in a delay line
  localparam int DL = FRAC_BITS + 5;
  logic [DL-1:0] z1_dl_r;
  always_ff @(posedge clk) begin
    if (en) z1_dl_r <= {z1_dl_r[DL-2:0], c1_z_r};
  end

  always_comb begin
    for (int k = 0; k < 6; k++) r0_d[k] = n2_side[k*DATA_WIDTH +: DATA_WIDTH];
  end

  logic signed [5:0][CW-1:0] c2;
  su3p_cross #(.AW(DATA_WIDTH), .BW(DATA_WIDTH), .RW(CW)) u_c2 (
    .clk(clk), .en(en), .p(row2), .q(r0_d), .d(c2)
  );

  logic          c2_v_r, c2_deg_r;
  logic [SW-1:0] c2_r0_r, c2_r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c2_v_r <= 1'b0;
    else if (en) c2_v_r <= n2_v;
    if (en) begin
      c2_deg_r <= n2_z || z1_dl_r[DL-1];
      c2_r0_r  <= n2_side;
      c2_r2_r  <= row2;
    end
  end
  assign pipe_out_v = c2_v_r;

  logic [SW-1:0] row1;
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      logic signed [CW:0] t;
      t = ($signed({c2[k][CW-1], c2[k]}) + ((CW+1)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (t > (CW+1)'(MAXV))      row1[k*DATA_WIDTH +: DATA_WIDTH] = MAXV;
      else if (t < (CW+1)'(MINV)) row1[k*DATA_WIDTH +: DATA_WIDTH] = MINV;
      else                        row1[k*DATA_WIDTH +: DATA_WIDTH] = DATA_WIDTH'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'(ROW_ZERO);
    end else begin
      if (pipe_out_v && en) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'(ROW_ZERO);
      end else if (out_tvalid && out_tready) begin
        if (cnt_r == 2'(ROW_TWO)) busy_r <= 1'b0;
        else cnt_r <= cnt_r + 2'd1;
      end
    end
    if (pipe_out_v && en) begin
      s0_r   <= c2_r0_r;
      s1_r   <= row1;
      s2_r   <= c2_r2_r;
      sdeg_r <= c2_deg_r;
    end
  end

  always_comb begin
    out_tvalid = busy_r;
    out_tlast  = (cnt_r == 2'(ROW_TWO));
    out_tuser  = {sdeg_r, cnt_r};
    unique case (cnt_r)
      2'(ROW_ZERO): out_tdata = s0_r;
      2'(ROW_ONE):  out_tdata = s1_r;
      default:      out_tdata = s2_r;
    endcase
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 2'd3) else $error("row counter out of range");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !busy_r || cnt_r == 2'(ROW_ZERO))
    else $error("run did not restart");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_out_v && busy_r && !last_take |-> !en) else $error("pipeline overrun");

endmodule
`default_nettype wire

FILE: hdl/su3p_norm.sv
`default_nettype none
// normalizes a three element complex vector: squared norm, then a bit-serial
// quotient search per element, one quotient bit per pipeline stage
// squares come from half-width partial products; the search keeps the
// remainder and q*norm so each stage needs only shifts, adds and a compare
module su3p_norm #(
  parameter int DATA_WIDTH = su3p_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = su3p_pkg::FRAC_BITS_DEF,
  parameter int VW         = 2 * DATA_WIDTH + 4
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               en,
  input  wire                               in_valid,
  input  wire  signed [5:0][VW-1:0]         in_vec,
  input  wire         [3*DATA_WIDTH*2-1:0]  in_side,
  output logic                              out_valid,
  output logic                              out_zero,
  output logic signed [5:0][DATA_WIDTH-1:0] out_vec,
  output logic        [3*DATA_WIDTH*2-1:0]  out_side
);
  import su3p_pkg::*;

  localparam int NW   = 2 * VW + 3;
  localparam int NS   = FRAC_BITS + 1;
  localparam int QW   = FRAC_BITS + 2;
  localparam int TW   = NW + 2 * FRAC_BITS + 4;
  localparam int LO   = VW / 2;
  localparam int HI   = VW - LO;
  localparam int LW   = ((QW + 1 > DATA_WIDTH) ? QW + 1 : DATA_WIDTH) + 1;
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // stage a: magnitudes
  logic                 va_r;
  logic [5:0][VW-1:0]   mag_a_r;
  logic [5:0]           neg_a_r;
  logic [3*DATA_WIDTH*2-1:0] side_a_r;

  // stage b: partial products
  logic                 vb_r;
  logic [5:0][2*HI-1:0] hh_b_r;
  logic [5:0][VW-1:0]   hl_b_r;
  logic [5:0][2*LO-1:0] ll_b_r;
  logic [5:0]           neg_b_r;
  logic [3*DATA_WIDTH*2-1:0] side_b_r;

  // stage c: squares
  logic                 vc_r;
  logic [5:0][2*VW-1:0] sq_c_r;
  logic [5:0]           neg_c_r;
  logic [3*DATA_WIDTH*2-1:0] side_c_r;

  // search stages
  logic [NS:0]                       vs_r;
  logic [NS:0][NW-1:0]               norm_s_r;
  logic [NS:0][5:0][TW-1:0]          rem_s_r;
  logic [NS:0][5:0][TW-1:0]          acc_s_r;
  logic [NS:0][5:0][QW-1:0]          q_s_r;
  logic [NS:0][5:0]                  neg_s_r;
  logic [NS:0][3*DATA_WIDTH*2-1:0]   side_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vs_r <= '0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vs_r <= {vs_r[NS-1:0], vc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        neg_a_r[k] <= in_vec[k][VW-1];
        mag_a_r[k] <= in_vec[k][VW-1] ? VW'(-in_vec[k]) : in_vec[k];
      end
      side_a_r <= in_side;
      for (int k = 0; k < 6; k++) begin
        hh_b_r[k] <= mag_a_r[k][VW-1:LO] * mag_a_r[k][VW-1:LO];
        hl_b_r[k] <= mag_a_r[k][VW-1:LO] * mag_a_r[k][LO-1:0];
        ll_b_r[k] <= mag_a_r[k][LO-1:0] * mag_a_r[k][LO-1:0];
      end
      neg_b_r  <= neg_a_r;
      side_b_r <= side_a_r;
      for (int k = 0; k < 6; k++) begin
        sq_c_r[k] <= ((2*VW)'(hh_b_r[k]) << (2 * LO)) + ((2*VW)'(hl_b_r[k]) << (LO + 1)) +
                     (2*VW)'(ll_b_r[k]);
      end
      neg_c_r  <= neg_b_r;
      side_c_r <= side_b_r;
      norm_s_r[0] <= NW'(sq_c_r[0]) + NW'(sq_c_r[1]) + NW'(sq_c_r[2]) +
                     NW'(sq_c_r[3]) + NW'(sq_c_r[4]) + NW'(sq_c_r[5]);
      neg_s_r[0]  <= neg_c_r;
      side_s_r[0] <= side_c_r;
      for (int k = 0; k < 6; k++) begin
        rem_s_r[0][k] <= TW'(sq_c_r[k]) << (2 * FRAC_BITS);
        acc_s_r[0][k] <= '0;
        q_s_r[0][k]   <= '0;
      end
      for (int s = 0; s < NS; s++) begin
        norm_s_r[s+1] <= norm_s_r[s];
        neg_s_r[s+1]  <= neg_s_r[s];
        side_s_r[s+1] <= side_s_r[s];
        for (int k = 0; k < 6; k++) begin
          logic [TW-1:0] trial;
          trial = (acc_s_r[s][k] << (FRAC_BITS - s + 1)) +
                  (TW'(norm_s_r[s]) << (2 * (FRAC_BITS - s)));
          if (trial <= rem_s_r[s][k]) begin
            rem_s_r[s+1][k] <= rem_s_r[s][k] - trial;
            acc_s_r[s+1][k] <= acc_s_r[s][k] + (TW'(norm_s_r[s]) << (FRAC_BITS - s));
            q_s_r[s+1][k]   <= q_s_r[s][k] | (QW'(1) << (FRAC_BITS - s));
          end else begin
            rem_s_r[s+1][k] <= rem_s_r[s][k];
            acc_s_r[s+1][k] <= acc_s_r[s][k];
            q_s_r[s+1][k]   <= q_s_r[s][k];
          end
        end
      end
    end
  end

  always_comb begin
    out_valid = vs_r[NS];
    out_zero  = (norm_s_r[NS] == '0);
    out_side  = side_s_r[NS];
    for (int k = 0; k < 6; k++) begin
      logic signed [LW-1:0] v;
      v = LW'(q_s_r[NS][k]);
      if (neg_s_r[NS][k]) v = -v;
      if (out_zero)                out_vec[k] = '0;
      else if (v > LW'(MAXV))      out_vec[k] = MAXV;
      else if (v < LW'(MINV))      out_vec[k] = MINV;
      else                         out_vec[k] = DATA_WIDTH'(v);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/su3p_cross.sv
`default_nettype none
// registered conjugate cross product: products then differences
module su3p_cross #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int RW = AW + BW + 3
) (
  input  wire                       clk,
  input  wire                       en,
  input  wire  signed [5:0][AW-1:0] p,
  input  wire  signed [5:0][BW-1:0] q,
  output logic signed [5:0][RW-1:0] d
);
  import su3p_pkg::*;

  logic signed [2:0][7:0][AW+BW-1:0] pr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        int i, j;
        i = (k + 1) % 3;
        j = (k + 2) % 3;
        pr_r[k][0] <= $signed(p[2*i]) * $signed(q[2*j]);
        pr_r[k][1] <= $signed(p[2*i+1]) * $signed(q[2*j+1]);
        pr_r[k][2] <= $signed(p[2*i]) * $signed(q[2*j+1]);
        pr_r[k][3] <= $signed(p[2*i+1]) * $signed(q[2*j]);
        pr_r[k][4] <= $signed(p[2*j]) * $signed(q[2*i]);
        pr_r[k][5] <= $signed(p[2*j+1]) * $signed(q[2*i+1]);
        pr_r[k][6] <= $signed(p[2*j]) * $signed(q[2*i+1]);
        pr_r[k][7] <= $signed(p[2*j+1]) * $signed(q[2*i]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[2*k] = RW'($signed(pr_r[k][0])) - RW'($signed(pr_r[k][1])) -
               RW'($signed(pr_r[k][4])) + RW'($signed(pr_r[k][5]));
      d[2*k+1] = RW'($signed(pr_r[k][6])) + RW'($signed(pr_r[k][7])) -
                 RW'($signed(pr_r[k][2])) - RW'($signed(pr_r[k][3]));
    end
  end

endmodule
`default_nettype wire
